// ----- rtl/core/spt_pkg.sv -----
// Shared types and constants of the script push tokenizer.
package spt_pkg;

	localparam logic [7:0] PUSH_DIRECT_MAX = 8'd75;
	localparam logic [7:0] OP_PUSHDATA1    = 8'd76;
	localparam logic [7:0] OP_PUSHDATA2    = 8'd77;
	localparam logic [7:0] VARINT_16       = 8'hFD;
	localparam logic [7:0] VARINT_32       = 8'hFE;

	typedef enum logic [2:0] {
		KIND_PREFIX  = 3'd0,
		KIND_PLAIN   = 3'd1,
		KIND_PUSHOP  = 3'd2,
		KIND_PUSHLEN = 3'd3,
		KIND_DATA    = 3'd4
	} spt_kind_t;

	typedef enum logic [2:0] {
		PH_PREFIX      = 3'd0,
		PH_PREFIX_MORE = 3'd1,
		PH_OPCODE      = 3'd2,
		PH_PUSHLEN     = 3'd3,
		PH_DATA        = 3'd4
	} spt_phase_t;

	typedef struct packed {
		spt_phase_t  phase;
		logic [3:0]  prefix_left;
		logic [3:0]  prefix_idx;
		logic [31:0] len_acc;
		logic [31:0] script_left;
		logic [1:0]  plen_left;
		logic [15:0] push_left;
		logic        wide;
	} spt_state_t;

	typedef struct packed {
		spt_kind_t  kind;
		logic [7:0] value;
		logic       push_last;
		logic       script_last;
		logic       overrun;
	} spt_result_t;

	localparam spt_state_t STATE_RESET = '{
		phase: PH_PREFIX, prefix_left: 4'd0, prefix_idx: 4'd0, len_acc: 32'd0,
		script_left: 32'd0, plen_left: 2'd0, push_left: 16'd0, wide: 1'b0
	};

endpackage

// ----- rtl/core/spt_byte_if.sv -----
// Channel that carries raw script bytes.
interface spt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/spt_tok_if.sv -----
// Channel that carries tagged script bytes.
interface spt_tok_if;
	logic       valid;
	logic       ready;
	logic [2:0] byte_kind;
	logic [7:0] byte_value;
	logic       push_last;
	logic       script_last;
	logic       overrun;

	modport source(output valid, output byte_kind, output byte_value, output push_last,
		output script_last, output overrun, input ready);
	modport sink(input valid, input byte_kind, input byte_value, input push_last,
		input script_last, input overrun, output ready);
endinterface

// ----- rtl/core/script_push_tokenizer_unit.sv -----
// Top level of the script push tokenizer: input stage, parser state and result register.
//
// Tags a serialized script stream at one byte per clock, sustained while tokens
// is not stalled. Every byte accepted on bytes produces exactly one beat on
// tokens: the byte is first held in the input register, then classified against
// the parser state and written to the result register. The parser state (varint
// prefix, script byte count, push length and count) is updated in the same cycle
// the byte moves into the result register, so the rate is set by that single
// state loop and is one byte per cycle. A stall on tokens holds both stages; up
// to two bytes are in flight.
module script_push_tokenizer_unit
	import spt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	spt_byte_if.sink   bytes,
	spt_tok_if.source  tokens
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        tok_valid_q;
	spt_result_t tok_q;
	spt_state_t  state_q;
	spt_state_t  state_nxt;
	spt_result_t res;
	logic        advance;

	assign advance     = valid_s1 && (!tok_valid_q || tokens.ready);
	assign bytes.ready = !valid_s1 || advance;

	spt_classifier u_classifier (
		.cur     (state_q),
		.in_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tok_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				tok_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (tokens.ready) begin
				tok_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.in_byte;
		end
		if (advance) begin
			tok_q <= res;
		end
	end

	assign tokens.valid       = tok_valid_q;
	assign tokens.byte_kind   = tok_q.kind;
	assign tokens.byte_value  = tok_q.value;
	assign tokens.push_last   = tok_q.push_last;
	assign tokens.script_last = tok_q.script_last;
	assign tokens.overrun     = tok_q.overrun;

	// A push can only end on a data byte.
	a_push_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.push_last |-> tokens.byte_kind == KIND_DATA)
		else $error("push_last on a byte that is not push data");

	// The last script byte always returns the parser to the length prefix.
	a_script_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.script_last |=> state_q.phase == PH_PREFIX)
		else $error("parser did not return to the prefix after script end");

	// While inside the script body there must be script bytes left to count.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_OPCODE || state_q.phase == PH_PUSHLEN
			|| state_q.phase == PH_DATA) |-> state_q.script_left != 32'd0)
		else $error("script body phase with no bytes left");

	// A data phase always has at least one push byte outstanding.
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.push_left != 16'd0)
		else $error("data phase with an empty push");

	// The result register only changes on a completed output beat or an empty slot.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid_q && !tokens.ready |=> tok_valid_q && $stable(tok_q))
		else $error("stalled result register changed");

endmodule

// ----- rtl/core/spt_classifier.sv -----
// Next-state and tag logic for one script byte.
module spt_classifier
	import spt_pkg::*;
(
	input  spt_state_t  cur,
	input  logic [7:0]  in_byte,
	output spt_state_t  nxt,
	output spt_result_t res
);

	logic [31:0] acc_new;
	logic [31:0] sl;
	logic        ends;
	logic [3:0]  pleft_new;
	logic [1:0]  plen_new;
	logic [15:0] plen_val;
	logic [15:0] pdata_new;

	always_comb begin
		nxt             = cur;
		res.kind        = KIND_PREFIX;
		res.value       = in_byte;
		res.push_last   = 1'b0;
		res.script_last = 1'b0;
		res.overrun     = 1'b0;
		acc_new         = cur.len_acc;
		sl              = cur.script_left - 32'd1;
		ends            = (sl == 32'd0);
		pleft_new       = cur.prefix_left - 4'd1;
		plen_new        = cur.plen_left - 2'd1;
		plen_val        = (cur.plen_left == 2'd2 || !cur.wide) ? {8'd0, in_byte}
			: {in_byte, cur.push_left[7:0]};
		pdata_new       = cur.push_left - 16'd1;

		unique case (cur.phase)
			PH_PREFIX: begin
				if (in_byte < VARINT_16) begin
					nxt.len_acc     = {24'd0, in_byte};
					nxt.script_left = {24'd0, in_byte};
					if (in_byte == 8'd0) begin
						res.script_last = 1'b1;
						nxt.phase       = PH_PREFIX;
					end else begin
						nxt.phase = PH_OPCODE;
					end
				end else begin
					nxt.prefix_left = (in_byte == VARINT_16) ? 4'd2
						: (in_byte == VARINT_32) ? 4'd4 : 4'd8;
					nxt.prefix_idx  = 4'd0;
					nxt.len_acc     = 32'd0;
					nxt.phase       = PH_PREFIX_MORE;
				end
			end
			PH_PREFIX_MORE: begin
				// Bytes past the low four only matter when nonzero: they saturate.
				if (cur.prefix_idx < 4'd4) begin
					acc_new = cur.len_acc | ({24'd0, in_byte} << {cur.prefix_idx[1:0], 3'b000});
				end else if (in_byte != 8'd0) begin
					acc_new     = 32'hFFFF_FFFF;
					res.overrun = 1'b1;
				end
				nxt.len_acc     = acc_new;
				nxt.prefix_idx  = cur.prefix_idx + 4'd1;
				nxt.prefix_left = pleft_new;
				if (pleft_new == 4'd0) begin
					nxt.script_left = acc_new;
					if (acc_new == 32'd0) begin
						res.script_last = 1'b1;
						nxt.phase       = PH_PREFIX;
					end else begin
						nxt.phase = PH_OPCODE;
					end
				end
			end
			PH_OPCODE, PH_PUSHLEN, PH_DATA: begin
				nxt.script_left = sl;
				if (cur.phase == PH_OPCODE) begin
					if (in_byte >= 8'd1 && in_byte <= PUSH_DIRECT_MAX) begin
						res.kind      = KIND_PUSHOP;
						nxt.push_left = {8'd0, in_byte};
						res.overrun   = ({24'd0, in_byte} > sl);
						nxt.phase     = PH_DATA;
					end else if (in_byte == OP_PUSHDATA1 || in_byte == OP_PUSHDATA2) begin
						res.kind      = KIND_PUSHOP;
						nxt.wide      = (in_byte == OP_PUSHDATA2);
						nxt.plen_left = (in_byte == OP_PUSHDATA2) ? 2'd2 : 2'd1;
						nxt.push_left = 16'd0;
						res.overrun   = ends;
						nxt.phase     = PH_PUSHLEN;
					end else begin
						res.kind = KIND_PLAIN;
					end
				end else if (cur.phase == PH_PUSHLEN) begin
					res.kind      = KIND_PUSHLEN;
					nxt.push_left = plen_val;
					nxt.plen_left = plen_new;
					if (plen_new == 2'd0) begin
						res.overrun = ({16'd0, plen_val} > sl);
						nxt.phase   = (plen_val == 16'd0) ? PH_OPCODE : PH_DATA;
					end else begin
						res.overrun = ends;
					end
				end else begin
					res.kind      = KIND_DATA;
					nxt.push_left = pdata_new;
					res.push_last = (pdata_new == 16'd0) || ends;
					if (pdata_new == 16'd0) begin
						nxt.phase = PH_OPCODE;
					end
				end
				if (ends) begin
					res.script_last = 1'b1;
					nxt.phase       = PH_PREFIX;
					nxt.plen_left   = 2'd0;
					nxt.push_left   = 16'd0;
					nxt.wide        = 1'b0;
				end
			end
			default: begin
				nxt = STATE_RESET;
			end
		endcase
	end

endmodule

// ----- verif/spt_token_checker.sv -----
// Checker that predicts the tag of every accepted script byte and compares the token beats.
module spt_token_checker
	import spt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	spt_byte_if  bytes,
	spt_tok_if   tokens,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	spt_phase_t  phase;
	logic [3:0]  prefix_left;
	logic [3:0]  prefix_idx;
	logic [31:0] length_acc;
	logic [31:0] script_left;
	logic [1:0]  len_bytes_left;
	logic [15:0] push_left;
	logic        wide_len;

	spt_result_t tokens_expected[$];
	spt_result_t want;

	// Loads the body count; an empty script ends on its last prefix byte.
	function automatic logic start_body(input logic [31:0] len);
		script_left = len;
		phase = (len == 32'd0) ? PH_PREFIX : PH_OPCODE;
		return (len == 32'd0);
	endfunction

	function automatic spt_result_t classify_byte(input logic [7:0] b);
		spt_result_t r;
		logic        ends;
		r = '{kind: KIND_PREFIX, value: b, push_last: 1'b0, script_last: 1'b0, overrun: 1'b0};
		case (phase)
			PH_PREFIX: begin
				if (b < VARINT_16) begin
					length_acc = 32'(b);
					r.script_last = start_body(32'(b));
				end else begin
					prefix_left = (b == VARINT_16) ? 4'd2 : (b == VARINT_32) ? 4'd4 : 4'd8;
					prefix_idx = 4'd0;
					length_acc = 32'd0;
					phase = PH_PREFIX_MORE;
				end
			end
			PH_PREFIX_MORE: begin
				// Only the low four bytes fit; anything nonzero above saturates.
				if (prefix_idx < 4'd4) begin
					length_acc |= 32'(b) << (8 * prefix_idx);
				end else if (b != 8'd0) begin
					length_acc = '1;
					r.overrun = 1'b1;
				end
				prefix_idx++;
				prefix_left--;
				if (prefix_left == 4'd0)
					r.script_last = start_body(length_acc);
			end
			default: begin
				script_left = script_left - 32'd1;
				ends = (script_left == 32'd0);
				if (phase == PH_OPCODE) begin
					if (b >= 8'd1 && b <= PUSH_DIRECT_MAX) begin
						r.kind = KIND_PUSHOP;
						push_left = 16'(b);
						r.overrun = (32'(b) > script_left);
						phase = PH_DATA;
					end else if (b == OP_PUSHDATA1 || b == OP_PUSHDATA2) begin
						r.kind = KIND_PUSHOP;
						wide_len = (b == OP_PUSHDATA2);
						len_bytes_left = wide_len ? 2'd2 : 2'd1;
						push_left = 16'd0;
						r.overrun = ends;
						phase = PH_PUSHLEN;
					end else begin
						r.kind = KIND_PLAIN;
					end
				end else if (phase == PH_PUSHLEN) begin
					r.kind = KIND_PUSHLEN;
					if (len_bytes_left == 2'd2 || !wide_len)
						push_left = 16'(b);
					else
						push_left = {b, push_left[7:0]};
					len_bytes_left--;
					if (len_bytes_left == 2'd0) begin
						r.overrun = (32'(push_left) > script_left);
						phase = (push_left == 16'd0) ? PH_OPCODE : PH_DATA;
					end else begin
						r.overrun = ends;
					end
				end else begin
					r.kind = KIND_DATA;
					push_left--;
					r.push_last = (push_left == 16'd0) || ends;
					if (push_left == 16'd0)
						phase = PH_OPCODE;
				end
				if (ends) begin
					r.script_last = 1'b1;
					phase = PH_PREFIX;
					len_bytes_left = 2'd0;
					push_left = 16'd0;
					wide_len = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_PREFIX;
			prefix_left = 4'd0;
			prefix_idx = 4'd0;
			length_acc = 32'd0;
			script_left = 32'd0;
			len_bytes_left = 2'd0;
			push_left = 16'd0;
			wide_len = 1'b0;
			tokens_expected.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// Results are checked before this edge's input is predicted, so a beat
			// can never be matched against the byte accepted in the same cycle.
			if (tokens.valid && tokens.ready) begin
				if (tokens_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected token beat: kind %0d value %02h", tokens.byte_kind,
							tokens.byte_value);
				end else begin
					want = tokens_expected.pop_front();
					if (tokens.byte_kind !== want.kind || tokens.byte_value !== want.value ||
						tokens.push_last !== want.push_last ||
						tokens.script_last !== want.script_last ||
						tokens.overrun !== want.overrun) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"token mismatch: expected kind %0d value %02h push_last %0b ",
								"script_last %0b overrun %0b, got kind %0d value %02h push_last %0b ",
								"script_last %0b overrun %0b"}, want.kind, want.value,
								want.push_last, want.script_last, want.overrun, tokens.byte_kind,
								tokens.byte_value, tokens.push_last, tokens.script_last,
								tokens.overrun);
					end
				end
			end
			if (bytes.valid && bytes.ready)
				tokens_expected.insert(tokens_expected.size(), classify_byte(bytes.in_byte));
			outstanding = tokens_expected.size();
		end
	end

endmodule

// ----- verif/script_push_tokenizer_unit_test.sv -----
// Top of the script push tokenizer testbench: clock, reset, byte stimulus and verdict.
module script_push_tokenizer_unit_test
	import spt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD       = 10;
	localparam int ITEM_TARGET      = 1700;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES     = 8;

	localparam logic [7:0] OP_FALSE     = 8'h00;
	localparam logic [7:0] OP_PUSHDATA4 = 8'h4E;
	localparam logic [7:0] OP_INVALID   = 8'hFF;
	localparam logic [7:0] VARINT_64    = 8'hFF;

	typedef enum {PFX_BYTE, PFX_WORD, PFX_DWORD, PFX_QWORD} prefix_form_t;

	// Empty script, mixed opcodes with a PUSHDATA1, an oversized direct push,
	// a PUSHDATA2 cut at the script end, and a PUSHDATA1 as the final byte.
	localparam logic [7:0] WARMUP_BYTES[24] = '{
		8'h00,
		8'h06, OP_FALSE, OP_PUSHDATA1, 8'h01, 8'hAA, OP_PUSHDATA4, OP_INVALID,
		VARINT_16, 8'h03, 8'h00, PUSH_DIRECT_MAX, 8'h5A, 8'hA5,
		VARINT_32, 8'h03, 8'h00, 8'h00, 8'h00, OP_PUSHDATA2, 8'h01, 8'h00,
		8'h01, OP_PUSHDATA1
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int   mismatch_count;
	int   tokens_due;
	int   items_sent = 0;
	int   hold_requests = 0;
	int   quiet_cycles = 0;
	bit   src_idle_en = 1'b0;
	bit   sink_idle_en = 1'b0;
	logic [7:0] script_body[$];

	spt_byte_if byte_ch();
	spt_tok_if  tok_ch();

	script_push_tokenizer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (tok_ch)
	);

	spt_token_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.bytes       (byte_ch),
		.tokens      (tok_ch),
		.mismatches  (mismatch_count),
		.outstanding (tokens_due)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int idle_length();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 60)) :
			int'($urandom_range(1, 3));
	endfunction

	function automatic void append_body(input logic [7:0] value);
		script_body.insert(script_body.size(), value);
	endfunction

	task automatic send_byte(input logic [7:0] value);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat (idle_length()) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= value;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic add_push_data(input int count);
		repeat (count) append_body(8'($urandom_range(0, 255)));
	endtask

	task automatic fill_noise(input int count);
		script_body.delete();
		add_push_data(count);
	endtask

	// Builds a body out of whole opcodes and pushes; a clipped body is cut at a
	// random point and has one byte overwritten.
	task automatic compose_script(input bit clipped);
		int target;
		int n;
		int cut;
		script_body.delete();
		target = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 40);
		while (script_body.size() < target) begin
			case ($urandom_range(0, 3))
				0: begin
					append_body(($urandom_range(0, 4) == 0) ? OP_FALSE :
						8'($urandom_range(OP_PUSHDATA4, 255)));
				end
				1: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, PUSH_DIRECT_MAX) :
						$urandom_range(1, 6);
					append_body(8'(n));
					add_push_data(n);
				end
				2: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
					append_body(OP_PUSHDATA1);
					append_body(8'(n));
					add_push_data(n);
				end
				default: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 8);
					append_body(OP_PUSHDATA2);
					append_body(n[7:0]);
					append_body(n[15:8]);
					add_push_data(n);
				end
			endcase
		end
		if (clipped) begin
			cut = $urandom_range(0, script_body.size());
			while (script_body.size() > cut) void'(script_body.pop_back());
			if (script_body.size() > 0)
				script_body[$urandom_range(0, script_body.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endtask

	// Sends the varint length of the current body, often in a non-minimal form, then the body itself.
	task automatic send_script();
		logic [31:0]  len;
		prefix_form_t form;
		len = 32'(script_body.size());
		if (len < VARINT_16 && $urandom_range(0, 3) != 0)
			form = PFX_BYTE;
		else
			form = prefix_form_t'($urandom_range(PFX_WORD, PFX_QWORD));
		case (form)
			PFX_BYTE: send_byte(len[7:0]);
			PFX_WORD: begin
				send_byte(VARINT_16);
				send_byte(len[7:0]);
				send_byte(len[15:8]);
			end
			PFX_DWORD: begin
				send_byte(VARINT_32);
				for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8]);
			end
			default: begin
				send_byte(VARINT_64);
				for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8]);
				repeat (4) send_byte(8'h00);
			end
		endcase
		foreach (script_body[i]) send_byte(script_body[i]);
	endtask

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : token_sink
		int gap;
		int holds_done;
		gap = 0;
		holds_done = 0;
		tok_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				// Long back-pressure while the byte side keeps offering beats.
				holds_done++;
				tok_ch.ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
			end else if (gap > 0) begin
				tok_ch.ready <= 1'b0;
				gap--;
			end else begin
				tok_ch.ready <= 1'b1;
				if (sink_idle_en && $urandom_range(0, 2) == 0)
					gap = idle_length();
			end
		end
	end

	initial begin : byte_source
		int scripts;
		int mix;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(WARMUP_BYTES); i++) send_byte(WARMUP_BYTES[i]);

		scripts = 0;
		while (items_sent < ITEM_TARGET) begin
			if (scripts % 10 == 0) begin
				src_idle_en = ($urandom_range(0, 3) != 0);
				sink_idle_en = ($urandom_range(0, 3) != 0);
			end
			if (scripts == 15)
				hold_requests++;
			if (scripts == 30) begin
				byte_ch.valid <= 1'b0;
				wait (tokens_due == 0);
				@(negedge clk);
			end
			if (scripts == 40) begin
				fill_noise(252);
			end else if (scripts == 41) begin
				fill_noise(253);
			end else begin
				mix = $urandom_range(0, 9);
				if (mix < 7)
					compose_script(1'b0);
				else if (mix < 9)
					compose_script(1'b1);
				else
					fill_noise($urandom_range(0, 30));
			end
			send_script();
			scripts++;
		end

		// A saturated length leaves the block inside an endless script, so it goes last.
		send_byte(VARINT_64);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(1, 255)));
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		fill_noise(8);
		foreach (script_body[i]) send_byte(script_body[i]);

		byte_ch.valid <= 1'b0;
		wait (tokens_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && tokens_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/spt_pkg.sv
rtl/core/spt_byte_if.sv
rtl/core/spt_tok_if.sv
rtl/core/spt_classifier.sv
rtl/core/script_push_tokenizer_unit.sv
verif/spt_token_checker.sv
verif/script_push_tokenizer_unit_test.sv
